// File: design/xy_mesh_router_output_queues_top_macros.svh
// assertion macros for the xy mesh router output queues block
`ifndef XY_MESH_ROUTER_OUTPUT_QUEUES_TOP_MACROS_SVH
`define XY_MESH_ROUTER_OUTPUT_QUEUES_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define XYMR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xymr implication check failed");

// condition that must hold at every clock edge outside reset
`define XYMR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("xymr invariant check failed");

`endif

// File: design/xymr_pkg.sv
// shared types and constants of the xy mesh router output queues block
package xymr_pkg;

  localparam int PORT_COUNT      = 5;
  localparam int PORT_W          = 3;
  localparam int COORD_W         = 5;
  localparam int TOKEN_W         = 32;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TOKEN_BITS_DEF  = 32;
  localparam int CMDQ_DEPTH      = 2;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;
  localparam int OWN_W           = 4;

  localparam logic [COORD_W-1:0] COORD_NONE = '1;

  // register index, taken from paddr bit 2
  localparam logic REG_OWN_X = 1'b0;
  localparam logic REG_OWN_Y = 1'b1;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [PORT_W-1:0] {
    PORT_LOCAL = 3'd0,
    PORT_NORTH = 3'd1,
    PORT_EAST  = 3'd2,
    PORT_SOUTH = 3'd3,
    PORT_WEST  = 3'd4
  } port_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_READ,
    BE_SEND
  } be_state_t;

  typedef struct packed {
    logic                is_tick;
    port_t               port;
    logic [COORD_W-1:0]  src_x;
    logic [COORD_W-1:0]  src_y;
    logic [COORD_W-1:0]  dest_x;
    logic [COORD_W-1:0]  dest_y;
    logic [TOKEN_W-1:0]  tok_re;
    logic [TOKEN_W-1:0]  tok_im;
  } cmd_t;

  // handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// File: design/xymr_front.sv
// front end: classifies input beats, routes arrivals and queues commands
module xymr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [xymr_pkg::OWN_W-1:0]          own_x,
  input  logic [xymr_pkg::OWN_W-1:0]          own_y,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [xymr_pkg::COORD_W-1:0] in_src_x,
  input  logic signed [xymr_pkg::COORD_W-1:0] in_src_y,
  input  logic signed [xymr_pkg::COORD_W-1:0] in_dest_x,
  input  logic signed [xymr_pkg::COORD_W-1:0] in_dest_y,
  input  logic signed [xymr_pkg::TOKEN_W-1:0] in_token_real,
  input  logic signed [xymr_pkg::TOKEN_W-1:0] in_token_imag,
  output xymr_pkg::cmd_chan_t                 cmd_out,
  input  logic                                cmd_pop
);

  localparam int QPTR_W = (xymr_pkg::CMDQ_DEPTH > 1) ? $clog2(xymr_pkg::CMDQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(xymr_pkg::CMDQ_DEPTH + 1);

  xymr_pkg::cmd_t     q_r [xymr_pkg::CMDQ_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  logic signed [xymr_pkg::COORD_W-1:0] ox, oy;
  logic                                src_empty, dest_bad, drop, push;
  xymr_pkg::port_t                     route;
  xymr_pkg::cmd_t                      cmd_new;

  assign ox = $signed({1'b0, own_x});
  assign oy = $signed({1'b0, own_y});

  assign src_empty = (in_src_x == xymr_pkg::COORD_NONE) && (in_src_y == xymr_pkg::COORD_NONE);
  assign dest_bad  = (in_dest_x == xymr_pkg::COORD_NONE) || (in_dest_y == xymr_pkg::COORD_NONE);
  assign drop      = (in_func == xymr_pkg::FUNC_ARRIVE) && (src_empty || dest_bad);

  // port order: local on a match, then east, south, west, and north otherwise
  always_comb begin
    if (in_dest_x == ox && in_dest_y == oy) begin
      route = xymr_pkg::PORT_LOCAL;
    end else if (in_dest_x > ox) begin
      route = xymr_pkg::PORT_EAST;
    end else if (in_dest_y > oy) begin
      route = xymr_pkg::PORT_SOUTH;
    end else if (in_dest_x < ox) begin
      route = xymr_pkg::PORT_WEST;
    end else begin
      route = xymr_pkg::PORT_NORTH;
    end
  end

  always_comb begin
    cmd_new.is_tick = (in_func == xymr_pkg::FUNC_TICK);
    cmd_new.port    = route;
    cmd_new.src_x   = in_src_x;
    cmd_new.src_y   = in_src_y;
    cmd_new.dest_x  = in_dest_x;
    cmd_new.dest_y  = in_dest_y;
    cmd_new.tok_re  = in_token_real;
    cmd_new.tok_im  = in_token_imag;
  end

  assign in_stall = (cnt_r == QCNT_W'(xymr_pkg::CMDQ_DEPTH));
  assign push     = in_valid && !in_stall && !drop;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(xymr_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(xymr_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

  assign cmd_out.valid = (cnt_r != '0);
  assign cmd_out.cmd   = q_r[rd_ptr_r];

endmodule

// File: design/xymr_back.sv
// back end: per-port packet queues, tick sequencer and result register
module xymr_back #(
  parameter int QUEUE_DEPTH = xymr_pkg::QUEUE_DEPTH_DEF,
  parameter int TOKEN_BITS  = xymr_pkg::TOKEN_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  xymr_pkg::cmd_chan_t                  cmd_in,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [xymr_pkg::PORT_W-1:0]          out_port,
  output logic                                 out_pkt_valid,
  output logic signed [xymr_pkg::COORD_W-1:0]  out_src_x,
  output logic signed [xymr_pkg::COORD_W-1:0]  out_src_y,
  output logic signed [xymr_pkg::COORD_W-1:0]  out_dest_x,
  output logic signed [xymr_pkg::COORD_W-1:0]  out_dest_y,
  output logic signed [xymr_pkg::TOKEN_W-1:0]  out_token_real,
  output logic signed [xymr_pkg::TOKEN_W-1:0]  out_token_imag,
  output logic [4:0]                           out_peak_fill,
  output logic                                 out_overflowed,
  output logic                                 out_last
);

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int PORT_W    = xymr_pkg::PORT_W;
  localparam int NPORT     = xymr_pkg::PORT_COUNT;
  localparam int ADDR_W    = PORT_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CRD_W     = 4 * xymr_pkg::COORD_W;
  localparam int ENT_W     = CRD_W + 2 * TOKEN_BITS;
  localparam int CW        = xymr_pkg::COORD_W;

  xymr_pkg::be_state_t state_r, state_nxt;

  logic [PTR_W-1:0]  head_r [NPORT];
  logic [PTR_W-1:0]  tail_r [NPORT];
  logic [CNT_W-1:0]  fill_r [NPORT];
  logic [CNT_W-1:0]  peak_r [NPORT];
  logic              ovf_r  [NPORT];

  logic [ENT_W-1:0]  mem [MEM_DEPTH];
  logic [ENT_W-1:0]  rd_data_r;
  logic              rd_hit_r;
  logic [CNT_W-1:0]  peak_cap_r;
  logic              ovf_cap_r;
  logic [PORT_W-1:0] port_r, port_nxt;

  logic              out_valid_r;
  logic [PORT_W-1:0] out_port_r;
  logic              out_pkt_valid_r;
  logic [CW-1:0]     out_src_x_r, out_src_y_r, out_dest_x_r, out_dest_y_r;
  logic [xymr_pkg::TOKEN_W-1:0] out_tok_re_r, out_tok_im_r;
  logic [4:0]        out_peak_r;
  logic              out_ovf_r;
  logic              out_last_r;

  logic [PORT_W-1:0] sel_port;
  logic [PTR_W-1:0]  sel_head, sel_tail;
  logic [CNT_W-1:0]  sel_fill, sel_peak, fill_inc;
  logic              sel_ovf, sel_full;
  logic              is_arrival, do_push, do_ovf, do_pop, out_free, load_out, at_last;
  logic [ENT_W-1:0]  wr_entry;

  logic signed [TOKEN_BITS-1:0] rd_re, rd_im;

  // one port is addressed per cycle: the arriving packet's or the tick's
  assign sel_port = (state_r == xymr_pkg::BE_IDLE) ? PORT_W'(cmd_in.cmd.port) : port_r;

  always_comb begin
    sel_head = '0;
    sel_tail = '0;
    sel_fill = '0;
    sel_peak = '0;
    sel_ovf  = 1'b0;
    for (int p = 0; p < NPORT; p++) begin
      if (sel_port == PORT_W'(p)) begin
        sel_head = head_r[p];
        sel_tail = tail_r[p];
        sel_fill = fill_r[p];
        sel_peak = peak_r[p];
        sel_ovf  = ovf_r[p];
      end
    end
  end

  assign sel_full   = (sel_fill == CNT_W'(QUEUE_DEPTH));
  assign fill_inc   = sel_fill + 1'b1;
  assign at_last    = (port_r == PORT_W'(NPORT - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign is_arrival = cmd_in.valid && !cmd_in.cmd.is_tick;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xymr_pkg::BE_IDLE: begin
        if (cmd_in.valid && cmd_in.cmd.is_tick) begin
          state_nxt = xymr_pkg::BE_READ;
        end
      end
      xymr_pkg::BE_READ: begin
        state_nxt = xymr_pkg::BE_SEND;
      end
      xymr_pkg::BE_SEND: begin
        if (out_free) begin
          state_nxt = at_last ? xymr_pkg::BE_IDLE : xymr_pkg::BE_READ;
        end
      end
      default: begin
        state_nxt = xymr_pkg::BE_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    do_push  = 1'b0;
    do_ovf   = 1'b0;
    do_pop   = 1'b0;
    load_out = 1'b0;
    port_nxt = port_r;
    unique case (state_r)
      xymr_pkg::BE_IDLE: begin
        cmd_pop  = cmd_in.valid;
        do_push  = is_arrival && !sel_full;
        do_ovf   = is_arrival && sel_full;
        port_nxt = '0;
      end
      xymr_pkg::BE_READ: begin
        do_pop = (sel_fill != '0);
      end
      xymr_pkg::BE_SEND: begin
        load_out = out_free;
        if (out_free && !at_last) begin
          port_nxt = port_r + 1'b1;
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xymr_pkg::BE_IDLE;
      port_r  <= '0;
      for (int p = 0; p < NPORT; p++) begin
        head_r[p] <= '0;
        tail_r[p] <= '0;
        fill_r[p] <= '0;
        peak_r[p] <= '0;
        ovf_r[p]  <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      port_r  <= port_nxt;
      for (int p = 0; p < NPORT; p++) begin
        if (sel_port == PORT_W'(p)) begin
          if (do_push) begin
            tail_r[p] <= (sel_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_tail + 1'b1;
            fill_r[p] <= fill_inc;
            if (fill_inc > sel_peak) begin
              peak_r[p] <= fill_inc;
            end
          end
          if (do_ovf) begin
            ovf_r[p] <= 1'b1;
          end
          if (do_pop) begin
            head_r[p] <= (sel_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
            fill_r[p] <= sel_fill - 1'b1;
          end
        end
      end
    end
  end

  assign wr_entry = {cmd_in.cmd.src_x, cmd_in.cmd.src_y, cmd_in.cmd.dest_x, cmd_in.cmd.dest_y,
                     cmd_in.cmd.tok_re[TOKEN_BITS-1:0], cmd_in.cmd.tok_im[TOKEN_BITS-1:0]};

  // queue storage: written in the idle state, read through a register in the read state, never both at once
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[{sel_port, sel_tail}] <= wr_entry;
    end
    if (do_pop) begin
      rd_data_r <= mem[{sel_port, sel_head}];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == xymr_pkg::BE_READ) begin
      rd_hit_r   <= (sel_fill != '0);
      peak_cap_r <= sel_peak;
      ovf_cap_r  <= sel_ovf;
    end
  end

  assign rd_re = rd_data_r[2*TOKEN_BITS-1:TOKEN_BITS];
  assign rd_im = rd_data_r[TOKEN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_port_r      <= port_r;
      out_pkt_valid_r <= rd_hit_r;
      out_peak_r      <= 5'(peak_cap_r);
      out_ovf_r       <= ovf_cap_r;
      out_last_r      <= at_last;
      if (rd_hit_r) begin
        out_src_x_r  <= rd_data_r[ENT_W-1 -: CW];
        out_src_y_r  <= rd_data_r[ENT_W-CW-1 -: CW];
        out_dest_x_r <= rd_data_r[ENT_W-2*CW-1 -: CW];
        out_dest_y_r <= rd_data_r[ENT_W-3*CW-1 -: CW];
        out_tok_re_r <= xymr_pkg::TOKEN_W'(rd_re);
        out_tok_im_r <= xymr_pkg::TOKEN_W'(rd_im);
      end else begin
        // empty packet
        out_src_x_r  <= xymr_pkg::COORD_NONE;
        out_src_y_r  <= xymr_pkg::COORD_NONE;
        out_dest_x_r <= xymr_pkg::COORD_NONE;
        out_dest_y_r <= xymr_pkg::COORD_NONE;
        out_tok_re_r <= '0;
        out_tok_im_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_port       = out_port_r;
  assign out_pkt_valid  = out_pkt_valid_r;
  assign out_src_x      = out_src_x_r;
  assign out_src_y      = out_src_y_r;
  assign out_dest_x     = out_dest_x_r;
  assign out_dest_y     = out_dest_y_r;
  assign out_token_real = out_tok_re_r;
  assign out_token_imag = out_tok_im_r;
  assign out_peak_fill  = out_peak_r;
  assign out_overflowed = out_ovf_r;
  assign out_last       = out_last_r;

endmodule

// File: design/xy_mesh_router_output_queues_top.sv
// top level of the xy mesh router node with five output queues
//
//  channel | direction | handshake            | beat
//  in_     | input     | in_valid / in_stall   | one arrival or one tick
//  out_    | output    | out_valid / out_stall | one port result, five per tick
//  cfg     | input     | apb psel / penable    | own_x at 0x0, own_y at 0x4
//
// an arrival enters a 2-entry command queue and is pushed by the back end while idle
// a tick leaves the queue while the back end is idle, then each port passes
// through a queue read state and then a result load state, which out_stall can hold
// in_stall is high while the command queue is full; out_stall holds the result register
// synchronous reset clears pointers, fill counts, peaks and overflow flags
// queue storage is not cleared; entries are only read after being written
module xy_mesh_router_output_queues_top #(
  parameter int QUEUE_DEPTH = xymr_pkg::QUEUE_DEPTH_DEF,
  parameter int TOKEN_BITS  = xymr_pkg::TOKEN_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [xymr_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [xymr_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [xymr_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_func,
  input  logic signed [xymr_pkg::COORD_W-1:0]    in_src_x,
  input  logic signed [xymr_pkg::COORD_W-1:0]    in_src_y,
  input  logic signed [xymr_pkg::COORD_W-1:0]    in_dest_x,
  input  logic signed [xymr_pkg::COORD_W-1:0]    in_dest_y,
  input  logic signed [xymr_pkg::TOKEN_W-1:0]    in_token_real,
  input  logic signed [xymr_pkg::TOKEN_W-1:0]    in_token_imag,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [xymr_pkg::PORT_W-1:0]            out_port,
  output logic                                   out_pkt_valid,
  output logic signed [xymr_pkg::COORD_W-1:0]    out_src_x,
  output logic signed [xymr_pkg::COORD_W-1:0]    out_src_y,
  output logic signed [xymr_pkg::COORD_W-1:0]    out_dest_x,
  output logic signed [xymr_pkg::COORD_W-1:0]    out_dest_y,
  output logic signed [xymr_pkg::TOKEN_W-1:0]    out_token_real,
  output logic signed [xymr_pkg::TOKEN_W-1:0]    out_token_imag,
  output logic [4:0]                             out_peak_fill,
  output logic                                   out_overflowed,
  output logic                                   out_last
);

  `include "xy_mesh_router_output_queues_top_macros.svh"

  logic [xymr_pkg::OWN_W-1:0] own_x_r, own_y_r;
  xymr_pkg::cmd_chan_t        cmd_chan;
  logic                       cmd_pop;
  logic                       cfg_wr;
  logic                       empty_fields_ok;
  logic                       dest_fields_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_x_r <= '0;
      own_y_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        xymr_pkg::REG_OWN_X: own_x_r <= pwdata[xymr_pkg::OWN_W-1:0];
        xymr_pkg::REG_OWN_Y: own_y_r <= pwdata[xymr_pkg::OWN_W-1:0];
        default:             own_x_r <= own_x_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      xymr_pkg::REG_OWN_X: prdata = xymr_pkg::APB_DATA_W'(own_x_r);
      xymr_pkg::REG_OWN_Y: prdata = xymr_pkg::APB_DATA_W'(own_y_r);
      default:             prdata = '0;
    endcase
  end

  xymr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .own_x         (own_x_r),
    .own_y         (own_y_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_src_x      (in_src_x),
    .in_src_y      (in_src_y),
    .in_dest_x     (in_dest_x),
    .in_dest_y     (in_dest_y),
    .in_token_real (in_token_real),
    .in_token_imag (in_token_imag),
    .cmd_out       (cmd_chan),
    .cmd_pop       (cmd_pop)
  );

  xymr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_in         (cmd_chan),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_port       (out_port),
    .out_pkt_valid  (out_pkt_valid),
    .out_src_x      (out_src_x),
    .out_src_y      (out_src_y),
    .out_dest_x     (out_dest_x),
    .out_dest_y     (out_dest_y),
    .out_token_real (out_token_real),
    .out_token_imag (out_token_imag),
    .out_peak_fill  (out_peak_fill),
    .out_overflowed (out_overflowed),
    .out_last       (out_last)
  );

  assign empty_fields_ok = (out_src_x == xymr_pkg::COORD_NONE) &&
                           (out_src_y == xymr_pkg::COORD_NONE) &&
                           (out_dest_x == xymr_pkg::COORD_NONE) &&
                           (out_dest_y == xymr_pkg::COORD_NONE) &&
                           (out_token_real == '0) && (out_token_imag == '0);
  assign dest_fields_ok  = (out_dest_x != xymr_pkg::COORD_NONE) &&
                           (out_dest_y != xymr_pkg::COORD_NONE);

  // the fifth result of a tick belongs to the west port
  `XYMR_ASSERT_ALWAYS(a_last_is_west, !out_valid || !out_last || out_port == xymr_pkg::PORT_WEST)
  // an empty packet carries the empty coordinates and a zero payload
  `XYMR_ASSERT_IMPL(a_empty_pkt, out_valid && !out_pkt_valid, empty_fields_ok)
  // packets with an invalid destination were dropped at the front
  `XYMR_ASSERT_IMPL(a_sent_dest_ok, out_valid && out_pkt_valid, dest_fields_ok)

endmodule

// File: test/xy_mesh_router_output_queues_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the xy mesh router output queues block
module xy_mesh_router_output_queues_top_tb;

  localparam int QD             = xymr_pkg::QUEUE_DEPTH_DEF;
  localparam int TOK_BITS       = xymr_pkg::TOKEN_BITS_DEF;
  localparam int COORD_W        = xymr_pkg::COORD_W;
  localparam int TOKEN_W        = xymr_pkg::TOKEN_W;
  localparam int PORT_W         = xymr_pkg::PORT_W;
  localparam int PORT_COUNT     = xymr_pkg::PORT_COUNT;
  localparam int APB_ADDR_W     = xymr_pkg::APB_ADDR_W;
  localparam int APB_DATA_W     = xymr_pkg::APB_DATA_W;
  localparam int OWN_W          = xymr_pkg::OWN_W;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic signed [TOKEN_W-1:0] token_real;
    logic signed [TOKEN_W-1:0] token_imag;
  } beat_t;

  typedef struct packed {
    logic [PORT_W-1:0]         port;
    logic                      pkt_valid;
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [TOKEN_W-1:0]        token_real;
    logic [TOKEN_W-1:0]        token_imag;
    logic [4:0]                peak_fill;
    logic                      overflowed;
    logic                      last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic signed [COORD_W-1:0] in_src_x = '0, in_src_y = '0, in_dest_x = '0, in_dest_y = '0;
  logic signed [TOKEN_W-1:0] in_token_real = '0, in_token_imag = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic [PORT_W-1:0] out_port;
  logic out_pkt_valid;
  logic signed [COORD_W-1:0] out_src_x, out_src_y, out_dest_x, out_dest_y;
  logic signed [TOKEN_W-1:0] out_token_real, out_token_imag;
  logic [4:0] out_peak_fill;
  logic out_overflowed, out_last;

  xy_mesh_router_output_queues_top uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_src_x(in_src_x), .in_src_y(in_src_y), .in_dest_x(in_dest_x), .in_dest_y(in_dest_y),
    .in_token_real(in_token_real), .in_token_imag(in_token_imag),
    .out_valid(out_valid), .out_stall(out_stall), .out_port(out_port),
    .out_pkt_valid(out_pkt_valid), .out_src_x(out_src_x), .out_src_y(out_src_y),
    .out_dest_x(out_dest_x), .out_dest_y(out_dest_y),
    .out_token_real(out_token_real), .out_token_imag(out_token_imag),
    .out_peak_fill(out_peak_fill), .out_overflowed(out_overflowed), .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // router model state
  logic [OWN_W-1:0] own_x_cur = '0, own_y_cur = '0;
  beat_t slot_mem [PORT_COUNT*QD];
  int head_idx [PORT_COUNT] = '{default: 0};
  int tail_idx [PORT_COUNT] = '{default: 0};
  int fill_lvl [PORT_COUNT] = '{default: 0};
  int peak_lvl [PORT_COUNT] = '{default: 0};
  logic ovf_seen [PORT_COUNT] = '{default: 1'b0};

  beat_t pending [$];
  result_t results_due [$];
  int mismatches = 0;

  logic in_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  bit calm = 1'b0;
  int quiet_cycles = 0;

  function automatic void stage_beat(input beat_t b);
    pending.insert(pending.size(), b);
  endfunction

  function automatic logic [TOKEN_W-1:0] narrow_token(input logic [TOKEN_W-1:0] t);
    logic [TOKEN_W-1:0] m;
    m = (TOK_BITS >= TOKEN_W) ? '1 : ((32'd1 << TOK_BITS) - 32'd1);
    t = t & m;
    if (t[TOK_BITS-1]) t = t | ~m;
    return t;
  endfunction

  function automatic xymr_pkg::port_t route_port(input logic signed [COORD_W-1:0] dx,
                                                 input logic signed [COORD_W-1:0] dy);
    logic signed [COORD_W-1:0] ox, oy;
    ox = $signed({1'b0, own_x_cur});
    oy = $signed({1'b0, own_y_cur});
    if (dx == ox && dy == oy) return xymr_pkg::PORT_LOCAL;
    else if (dx > ox) return xymr_pkg::PORT_EAST;
    else if (dy > oy) return xymr_pkg::PORT_SOUTH;
    else if (dx < ox) return xymr_pkg::PORT_WEST;
    else return xymr_pkg::PORT_NORTH;
  endfunction

  task automatic route_and_drain(input beat_t b);
    int p, slot;
    xymr_pkg::port_t dst;
    result_t r;
    if (b.func == xymr_pkg::FUNC_ARRIVE) begin
      if (!(b.src_x == xymr_pkg::COORD_NONE && b.src_y == xymr_pkg::COORD_NONE) &&
          b.dest_x != xymr_pkg::COORD_NONE && b.dest_y != xymr_pkg::COORD_NONE) begin
        dst = route_port(b.dest_x, b.dest_y);
        p = int'(dst);
        if (fill_lvl[p] >= QD) begin
          ovf_seen[p] = 1'b1;
        end else begin
          slot_mem[p*QD + tail_idx[p]] = b;
          tail_idx[p] = (tail_idx[p] + 1) % QD;
          fill_lvl[p]++;
          if (fill_lvl[p] > peak_lvl[p]) peak_lvl[p] = fill_lvl[p];
        end
      end
    end else begin
      for (p = 0; p < PORT_COUNT; p++) begin
        r.port = PORT_W'(p);
        if (fill_lvl[p] == 0) begin
          r.pkt_valid = 1'b0;
          r.src_x = xymr_pkg::COORD_NONE;
          r.src_y = xymr_pkg::COORD_NONE;
          r.dest_x = xymr_pkg::COORD_NONE;
          r.dest_y = xymr_pkg::COORD_NONE;
          r.token_real = '0;
          r.token_imag = '0;
        end else begin
          slot = p*QD + head_idx[p];
          r.pkt_valid = 1'b1;
          r.src_x = slot_mem[slot].src_x;
          r.src_y = slot_mem[slot].src_y;
          r.dest_x = slot_mem[slot].dest_x;
          r.dest_y = slot_mem[slot].dest_y;
          r.token_real = narrow_token(slot_mem[slot].token_real);
          r.token_imag = narrow_token(slot_mem[slot].token_imag);
          head_idx[p] = (head_idx[p] + 1) % QD;
          fill_lvl[p]--;
        end
        r.peak_fill = 5'(peak_lvl[p]);
        r.overflowed = ovf_seen[p];
        r.last = (p == PORT_COUNT - 1);
        results_due.insert(results_due.size(), r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  function automatic beat_t make_beat(input logic f, input int sx, input int sy,
                                      input int dx, input int dy,
                                      input logic [31:0] re, input logic [31:0] im);
    beat_t b;
    b.func = f;
    b.src_x = sx[COORD_W-1:0];
    b.src_y = sy[COORD_W-1:0];
    b.dest_x = dx[COORD_W-1:0];
    b.dest_y = dy[COORD_W-1:0];
    b.token_real = re;
    b.token_imag = im;
    return b;
  endfunction

  // mostly well-formed arrivals and ticks, some raw noise on every field
  function automatic beat_t rand_beat(input int tick_pct, input bit flood);
    beat_t b;
    b.token_real = $urandom;
    b.token_imag = $urandom;
    b.src_x = COORD_W'($urandom);
    b.src_y = COORD_W'($urandom);
    b.dest_x = COORD_W'($urandom);
    b.dest_y = COORD_W'($urandom);
    if ($urandom_range(0, 99) < 12) begin
      b.func = 1'($urandom_range(0, 1));
    end else if ($urandom_range(0, 99) < tick_pct) begin
      b.func = xymr_pkg::FUNC_TICK;
    end else begin
      b.func = xymr_pkg::FUNC_ARRIVE;
      do begin
        b.src_x = COORD_W'($urandom_range(0, 16) - 1);
        b.src_y = COORD_W'($urandom_range(0, 16) - 1);
      end while (b.src_x == xymr_pkg::COORD_NONE && b.src_y == xymr_pkg::COORD_NONE);
      if (flood && $urandom_range(0, 1) == 1) begin
        b.dest_x = $signed({1'b0, own_x_cur});
        b.dest_y = $signed({1'b0, own_y_cur});
      end else begin
        b.dest_x = COORD_W'($urandom_range(0, 15));
        b.dest_y = COORD_W'($urandom_range(0, 15));
      end
    end
    return b;
  endfunction

  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (pending.size() != 0 || in_valid || results_due.size() != 0);
    // an arrival can still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [OWN_W-1:0] ox, input logic [OWN_W-1:0] oy,
                           input int n, input int tick_pct, input bit flood,
                           input bit long_hold, input bit quiet_end);
    logic [APB_DATA_W-1:0] w, rd;
    int k;
    wait_quiet();
    w = $urandom;
    w[OWN_W-1:0] = ox;
    apb_access(1'b1, {xymr_pkg::REG_OWN_X, 2'b00}, w, rd);
    own_x_cur = ox;
    w = $urandom;
    w[OWN_W-1:0] = oy;
    apb_access(1'b1, {xymr_pkg::REG_OWN_Y, 2'b00}, w, rd);
    own_y_cur = oy;
    apb_access(1'b0, {xymr_pkg::REG_OWN_X, 2'b00}, '0, rd);
    check_field("own_x", 32'(ox), 32'(rd[OWN_W-1:0]));
    apb_access(1'b0, {xymr_pkg::REG_OWN_Y, 2'b00}, '0, rd);
    check_field("own_y", 32'(oy), 32'(rd[OWN_W-1:0]));
    @(posedge clk);
    if (long_hold) hold_requests++;
    calm = quiet_end;
    for (k = 0; k < n; k++) stage_beat(rand_beat(tick_pct, flood));
  endtask

  // sender
  always @(negedge clk) begin : sender
    beat_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled beat holds
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (!calm && pending.size() != 0 && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      gap_left <= $urandom_range(0, 4);
    end else if (pending.size() != 0) begin
      nb = pending[0];
      pending.delete(0);
      in_valid <= 1'b1;
      in_func <= nb.func;
      in_src_x <= nb.src_x;
      in_src_y <= nb.src_y;
      in_dest_x <= nb.dest_x;
      in_dest_y <= nb.dest_y;
      in_token_real <= nb.token_real;
      in_token_imag <= nb.token_imag;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      stall_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 15) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    beat_t ib;
    result_t er;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      ib.func = in_func;
      ib.src_x = in_src_x;
      ib.src_y = in_src_y;
      ib.dest_x = in_dest_x;
      ib.dest_y = in_dest_y;
      ib.token_real = in_token_real;
      ib.token_imag = in_token_imag;
      route_and_drain(ib);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected, out_port %0d", out_port);
        mismatches++;
      end else begin
        er = results_due[0];
        results_due.delete(0);
        check_field("out_port", 32'(er.port), 32'(out_port));
        check_field("pkt_valid", 32'(er.pkt_valid), 32'(out_pkt_valid));
        check_field("out_src_x", 32'(er.src_x), 32'(out_src_x));
        check_field("out_src_y", 32'(er.src_y), 32'(out_src_y));
        check_field("out_dest_x", 32'(er.dest_x), 32'(out_dest_x));
        check_field("out_dest_y", 32'(er.dest_y), 32'(out_dest_y));
        check_field("out_token_real", er.token_real, out_token_real);
        check_field("out_token_imag", er.token_imag, out_token_imag);
        check_field("peak_fill", 32'(er.peak_fill), 32'(out_peak_fill));
        check_field("overflowed", 32'(er.overflowed), 32'(out_overflowed));
        check_field("last", 32'(er.last), 32'(out_last));
      end
    end
  end

  // watchdog on cycles without any accepted beat or register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed beats at the reset position (0,0)
    stage_beat(make_beat(xymr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, -1, -1, 3, 3, 32'h1234, 32'h5678));
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, 2, 2, -1, 4, 32'h1, 32'h2));
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, 2, 2, 4, -1, 32'h3, 32'h4));
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, -1, 0, 15, 15, 32'h7FFFFFFF, 32'h80000000));
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, 15, -1, 0, 15, 32'h0, 32'hFFFFFFFF));
    // coordinates below -1 compare as signed: west and north
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, -16, -16, -16, 0, $urandom, $urandom));
    stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, 5, 7, 0, -16, $urandom, $urandom));
    // one more than the local queue holds
    for (i = 0; i < QD + 1; i++) begin
      if (i == 0)
        stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, i - 1, 15 - i, 0, 0,
                             32'h80000000, 32'h7FFFFFFF));
      else if (i == 1)
        stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, i - 1, 15 - i, 0, 0,
                             32'h0, 32'hFFFFFFFF));
      else
        stage_beat(make_beat(xymr_pkg::FUNC_ARRIVE, i - 1, 15 - i, 0, 0,
                             $urandom, $urandom));
    end
    stage_beat(make_beat(xymr_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));

    run_phase(4'd15, 4'd15, 80, 30, 1'b0, 1'b0, 1'b0);
    run_phase(4'd0, 4'd0, 80, 5, 1'b1, 1'b0, 1'b0);
    run_phase(4'd7, 4'd3, 90, 35, 1'b0, 1'b0, 1'b0);
    run_phase(4'd0, 4'd15, 60, 25, 1'b0, 1'b1, 1'b0);
    run_phase(4'd15, 4'd0, 60, 8, 1'b1, 1'b0, 1'b0);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 90, 45,
              1'b0, 1'b0, 1'b1);
    wait_quiet();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/xymr_pkg.sv
design/xymr_front.sv
design/xymr_back.sv
design/xy_mesh_router_output_queues_top.sv
test/xy_mesh_router_output_queues_top_tb.sv
